// ===== rtl/core/lc3_instruction_executor_macros.svh =====
// Assertion macros for the LC-3 executor.
`ifndef LC3_INSTRUCTION_EXECUTOR_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTOR_MACROS_SVH
// implication checked every edge outside reset
`define LC3_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lc3 check failed");
// next-cycle implication
`define LC3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lc3 check failed");
`endif

// ===== rtl/core/lc3_pkg.sv =====
// Package: constants, opcodes and types for the LC-3 executor.
package lc3_pkg;
   localparam int ADDR_BITS_DEFAULT = 16;
   localparam logic [15:0] START_PC_RESET = 16'h3000;
   localparam logic [1:0] CC_NEG = 2'd0;
   localparam logic [1:0] CC_ZERO = 2'd1;
   localparam logic [1:0] CC_POS = 2'd2;
   localparam logic [3:0] OP_BR = 4'd0;
   localparam logic [3:0] OP_ADD = 4'd1;
   localparam logic [3:0] OP_LD = 4'd2;
   localparam logic [3:0] OP_ST = 4'd3;
   localparam logic [3:0] OP_JSR = 4'd4;
   localparam logic [3:0] OP_AND = 4'd5;
   localparam logic [3:0] OP_LDR = 4'd6;
   localparam logic [3:0] OP_STR = 4'd7;
   localparam logic [3:0] OP_RTI = 4'd8;
   localparam logic [3:0] OP_NOT = 4'd9;
   localparam logic [3:0] OP_LDI = 4'd10;
   localparam logic [3:0] OP_STI = 4'd11;
   localparam logic [3:0] OP_JMP = 4'd12;
   localparam logic [3:0] OP_RES = 4'd13;
   localparam logic [3:0] OP_LEA = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   typedef struct packed {
      logic        func;
      logic [15:0] instruction_word;
      logic [15:0] load_address;
      logic [15:0] load_data;
   } req_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic [1:0]  condition;
      logic        reg_written;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic        mem_written;
      logic [15:0] store_address;
      logic [15:0] store_data;
      logic        trap_taken;
      logic [7:0]  trap_vector;
      logic        illegal;
   } rsp_type;

   function automatic logic [1:0] cc_of(input logic [15:0] v);
      if (v[15]) return CC_NEG;
      return (v == 16'd0) ? CC_ZERO : CC_POS;
   endfunction
endpackage

// ===== rtl/core/lc3_if.sv =====
// Valid/ready channel interface.
interface lc3_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/lc3_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
module lc3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/core/lc3_instruction_executor.sv =====
// LC-3 executor: one item (preload or instruction) per beat, one result beat each.
// Preloads, register/branch ops, ST and STR finish from idle; LD, LDR and STI
// finish in ST_RD1 after one registered RAM read; LDI reads twice, via ST_RD1, ST_RD2.
// A new item is taken only in ST_IDLE with the result slot free, so the single read port holds it off.
// Reset clears registers to zero, condition to CC_ZERO, PC and start_pc to
// START_PC_RESET; memory keeps no reset value.
module lc3_instruction_executor
   import lc3_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   lc3_if.sink         req,
   lc3_if.source       rsp
);
   `include "lc3_instruction_executor_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD1 = 2'd1;
   localparam logic [1:0] ST_RD2 = 2'd2;

   logic [15:0] start_pc_ff;
   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff;
   logic [1:0]  cc_ff;
   logic [1:0]  state_ff, state_in;
   logic [15:0] ins_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_load;

   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
   logic [15:0]          mem_wdata, mem_rdata;

   lc3_ram #(.WIDTH(16), .DEPTH(2 ** ADDR_BITS)) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   wire out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   wire acc = req.valid && req.ready;

   // decode of the instruction in flight (new beat or held word)
   logic [15:0] ins;
   assign ins = (state_ff == ST_IDLE) ? req.payload.instruction_word : ins_ff;
   wire [3:0]  op = ins[15:12];
   wire [2:0]  dr = ins[11:9];
   wire [2:0]  sr1 = ins[8:6];
   wire [15:0] pc1 = pc_ff + 16'd1;
   wire [15:0] off9 = {{7{ins[8]}}, ins[8:0]};
   wire [15:0] off6 = {{10{ins[5]}}, ins[5:0]};
   wire [15:0] off11 = {{5{ins[10]}}, ins[10:0]};
   wire [15:0] pcrel = pc1 + off9;
   wire [15:0] baserel = regs_ff[sr1] + off6;
   wire [15:0] imm5 = {{11{ins[4]}}, ins[4:0]};
   wire [15:0] opb = ins[5] ? imm5 : regs_ff[ins[2:0]];

   logic [1:0]  bit_sel;
   logic        br_take;
   always_comb begin
      bit_sel = cc_ff;
      unique case (bit_sel)
         CC_NEG:  br_take = dr[2];
         CC_ZERO: br_take = dr[1];
         default: br_take = dr[0];
      endcase
   end

   logic        rw, mw, reg_cc, done;
   logic [2:0]  ridx;
   logic [15:0] rval, npc, saddr;
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      rw = 1'b0; mw = 1'b0; reg_cc = 1'b0; done = 1'b0;
      ridx = dr; rval = 16'd0; npc = pc1; saddr = 16'd0;
      mem_raddr = pcrel[ADDR_BITS-1:0];
      rsp_in = '0;
      if (state_ff == ST_IDLE) begin
         if (acc && !req.payload.func) begin
            rsp_load = 1'b1;
            npc = pc_ff;
         end else if (acc) begin
            done = 1'b1;
            unique case (op) inside
               OP_ADD: begin rw = 1'b1; reg_cc = 1'b1; rval = regs_ff[sr1] + opb; end
               OP_AND: begin rw = 1'b1; reg_cc = 1'b1; rval = regs_ff[sr1] & opb; end
               OP_NOT: begin rw = 1'b1; reg_cc = 1'b1; rval = ~regs_ff[sr1]; end
               OP_LEA: begin rw = 1'b1; reg_cc = 1'b1; rval = pcrel; end
               OP_ST: begin mw = 1'b1; saddr = pcrel; end
               OP_STR: begin mw = 1'b1; saddr = baserel; end
               OP_BR: npc = br_take ? pcrel : pc1;
               OP_JMP: npc = regs_ff[sr1];
               OP_JSR: begin
                  rw = 1'b1; ridx = 3'd7; rval = pc1;
                  npc = ins[11] ? pc1 + off11 : regs_ff[sr1];
               end
               OP_TRAP: begin rw = 1'b1; ridx = 3'd7; rval = pc1; end
               OP_LD, OP_LDI, OP_STI: begin
                  done = 1'b0; state_in = ST_RD1;
               end
               OP_LDR: begin
                  done = 1'b0; state_in = ST_RD1;
                  mem_raddr = baserel[ADDR_BITS-1:0];
               end
               default: npc = pc_ff;
            endcase
         end
      end else if (state_ff == ST_RD1) begin
         if ((op == OP_LDI || op == OP_STI)) begin
            mem_raddr = mem_rdata[ADDR_BITS-1:0];
            if (op == OP_STI) begin
               done = 1'b1; mw = 1'b1; saddr = mem_rdata; state_in = ST_IDLE;
            end else begin
               state_in = ST_RD2;
            end
         end else begin
            done = 1'b1; rw = 1'b1; reg_cc = 1'b1; rval = mem_rdata; state_in = ST_IDLE;
         end
      end else begin
         done = 1'b1; rw = 1'b1; reg_cc = 1'b1; rval = mem_rdata; state_in = ST_IDLE;
      end
      if (done) begin
         rsp_load = 1'b1;
         rsp_in.next_pc = npc;
         rsp_in.condition = reg_cc ? cc_of(rval) : cc_ff;
         rsp_in.reg_written = rw;
         rsp_in.reg_index = rw ? ridx : 3'd0;
         rsp_in.reg_value = rval;
         rsp_in.mem_written = mw;
         if (mw) begin
            rsp_in.store_address = 16'(saddr[ADDR_BITS-1:0]);
            rsp_in.store_data = regs_ff[dr];
         end
         rsp_in.trap_taken = (op == OP_TRAP);
         rsp_in.trap_vector = (op == OP_TRAP) ? ins[7:0] : 8'd0;
         rsp_in.illegal = (op == OP_RTI) || (op == OP_RES);
      end else if (rsp_load) begin
         rsp_in.next_pc = pc_ff;
         rsp_in.condition = cc_ff;
      end
   end

   // memory write: preload beat or a finished store
   always_comb begin
      mem_we = 1'b0;
      mem_waddr = req.payload.load_address[ADDR_BITS-1:0];
      mem_wdata = req.payload.load_data;
      if (acc && !req.payload.func) begin
         mem_we = 1'b1;
      end else if (done && mw) begin
         mem_we = 1'b1;
         mem_waddr = saddr[ADDR_BITS-1:0];
         mem_wdata = regs_ff[dr];
      end
   end

   always_ff @(posedge clock) begin
      if (acc) ins_ff <= req.payload.instruction_word;
      if (rsp_load) rsp_ff <= rsp_in;
      if (reset) begin
         start_pc_ff <= START_PC_RESET;
         pc_ff <= START_PC_RESET;
         cc_ff <= CC_ZERO;
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
      end else begin
         if (csr_we) begin
            start_pc_ff <= csr_wdata;
         end
         state_ff <= state_in;
         if (done && rw) regs_ff[ridx] <= rval;
         if (done) begin
            pc_ff <= npc;
            if (reg_cc) cc_ff <= cc_of(rval);
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   `LC3_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req.ready)
   `LC3_ASSERT_NEXT(a_rd2_from_ldi, clock, reset, state_ff == ST_RD2, state_ff == ST_IDLE)
   `LC3_ASSERT_IMPL(a_one_write, clock, reset, mem_we && acc && !req.payload.func, !done)
   `LC3_ASSERT_NEXT(a_done_valid, clock, reset, done, rsp_valid_ff)
endmodule

// ===== sim/tb_lc3_instruction_executor.sv =====
// Testbench for the LC-3 instruction executor: directed and random beats against a local predictor.
`timescale 1ns / 1ps

module tb_lc3_instruction_executor;
   import lc3_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = 16'd0;

   lc3_if #(.payload_type(req_type)) req_if ();
   lc3_if #(.payload_type(rsp_type)) rsp_if ();

   lc3_instruction_executor uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_if),
      .rsp       (rsp_if)
   );

   // predicted architectural state
   logic [15:0] gpr [0:7];
   logic [15:0] arch_pc;
   logic [1:0]  arch_cc;
   logic [15:0] shadow_mem [0:65535];
   bit          mem_valid [0:65535];
   logic [15:0] start_pc_reg;

   req_type pending_items[$];
   rsp_type predicted_results[$];

   int errors = 0;
   int sent_beats = 0;
   int recv_beats = 0;
   int stall_left = 0;
   bit stall_done = 1'b0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic logic [1:0] flags_of(input logic [15:0] v);
      if (v[15]) return CC_NEG;
      return (v == 16'd0) ? CC_ZERO : CC_POS;
   endfunction

   task automatic execute_item(input req_type it, output rsp_type r);
      logic [15:0] ins, pcn, off9, off6, b, a, tgt;
      logic [3:0]  op;
      logic [2:0]  dr, sr1, nzp;
      logic        wr_reg;
      r = '0;
      if (!it.func) begin
         shadow_mem[it.load_address] = it.load_data;
         mem_valid[it.load_address] = 1'b1;
         r.next_pc = arch_pc;
         r.condition = arch_cc;
         return;
      end
      ins = it.instruction_word;
      op = ins[15:12];
      dr = ins[11:9];
      sr1 = ins[8:6];
      pcn = arch_pc + 16'd1;
      off9 = {{7{ins[8]}}, ins[8:0]};
      off6 = {{10{ins[5]}}, ins[5:0]};
      wr_reg = 1'b0;
      case (op) inside
         OP_ADD, OP_AND: begin
            b = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
            r.reg_value = (op == OP_ADD) ? gpr[sr1] + b : gpr[sr1] & b;
            wr_reg = 1'b1;
         end
         OP_NOT: begin
            r.reg_value = ~gpr[sr1];
            wr_reg = 1'b1;
         end
         OP_LD: begin
            r.reg_value = shadow_mem[16'(pcn + off9)];
            wr_reg = 1'b1;
         end
         OP_LDI: begin
            r.reg_value = shadow_mem[shadow_mem[16'(pcn + off9)]];
            wr_reg = 1'b1;
         end
         OP_LDR: begin
            r.reg_value = shadow_mem[16'(gpr[sr1] + off6)];
            wr_reg = 1'b1;
         end
         OP_LEA: begin
            r.reg_value = pcn + off9;
            wr_reg = 1'b1;
         end
         OP_ST, OP_STI, OP_STR: begin
            if (op == OP_ST) a = pcn + off9;
            else if (op == OP_STI) a = shadow_mem[16'(pcn + off9)];
            else a = gpr[sr1] + off6;
            r.mem_written = 1'b1;
            r.store_address = a;
            r.store_data = gpr[dr];
            shadow_mem[a] = gpr[dr];
            mem_valid[a] = 1'b1;
         end
         OP_BR: begin
            nzp = ins[11:9];
            if ((arch_cc == CC_NEG && nzp[2]) || (arch_cc == CC_ZERO && nzp[1]) ||
                (arch_cc == CC_POS && nzp[0]))
               pcn = pcn + off9;
         end
         OP_JMP: pcn = gpr[sr1];
         OP_JSR: begin
            // JSRR through R7 reads the base before the link write
            tgt = ins[11] ? pcn + {{5{ins[10]}}, ins[10:0]} : gpr[sr1];
            gpr[7] = pcn;
            r.reg_written = 1'b1;
            r.reg_index = 3'd7;
            r.reg_value = pcn;
            pcn = tgt;
         end
         OP_TRAP: begin
            gpr[7] = pcn;
            r.reg_written = 1'b1;
            r.reg_index = 3'd7;
            r.reg_value = pcn;
            r.trap_taken = 1'b1;
            r.trap_vector = ins[7:0];
         end
         default: begin
            r.illegal = 1'b1;
            pcn = arch_pc;
         end
      endcase
      if (wr_reg) begin
         r.reg_written = 1'b1;
         r.reg_index = dr;
         gpr[dr] = r.reg_value;
         arch_cc = flags_of(r.reg_value);
      end
      arch_pc = pcn;
      r.next_pc = arch_pc;
      r.condition = arch_cc;
   endtask

   task automatic queue_item(input req_type it);
      rsp_type r;
      execute_item(it, r);
      pending_items.push_back(it);
      predicted_results.push_back(r);
   endtask

   task automatic preload(input logic [15:0] addr, input logic [15:0] data);
      req_type it;
      it = '0;
      it.func = 1'b0;
      it.instruction_word = 16'($urandom);
      it.load_address = addr;
      it.load_data = data;
      queue_item(it);
   endtask

   // make sure a word is defined before an instruction reads it
   task automatic cover_word(input logic [15:0] addr);
      if (!mem_valid[addr]) preload(addr, 16'($urandom));
   endtask

   task automatic issue(input logic [15:0] ins);
      req_type it;
      logic [15:0] pcn, a1;
      pcn = arch_pc + 16'd1;
      a1 = pcn + {{7{ins[8]}}, ins[8:0]};
      case (ins[15:12]) inside
         OP_LD, OP_STI: cover_word(a1);
         OP_LDI: begin
            cover_word(a1);
            cover_word(shadow_mem[a1]);
         end
         OP_LDR: cover_word(gpr[ins[8:6]] + {{10{ins[5]}}, ins[5:0]});
         default: ;
      endcase
      it.func = 1'b1;
      it.instruction_word = ins;
      it.load_address = 16'($urandom);
      it.load_data = 16'($urandom);
      queue_item(it);
   endtask

   task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) begin
         $display("mismatch beat %0d %s: got %h expected %h", recv_beats, field, got, want);
         errors++;
      end
   endtask

   task automatic csr_write(input logic [15:0] v);
      wait (pending_items.size() == 0 && predicted_results.size() == 0);
      repeat (10) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      start_pc_reg = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) sent_beats++;
         if (!req_if.valid || req_if.ready) begin
            if (pending_items.size() > 0 &&
                ((sent_beats >= 400 && sent_beats < 550) || $urandom_range(99) >= 16)) begin
               req_if.valid <= 1'b1;
               req_if.payload <= pending_items.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result ready, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!stall_done && recv_beats >= 250) begin
         stall_done = 1'b1;
         stall_left = 300;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (recv_beats >= 400 && recv_beats < 550) || $urandom_range(99) >= 16;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (predicted_results.size() == 0) begin
            $display("unexpected result beat %0d", recv_beats);
            errors++;
         end else begin
            want = predicted_results.pop_front();
            report("next_pc", got.next_pc, want.next_pc);
            report("condition", 16'(got.condition), 16'(want.condition));
            report("reg_written", 16'(got.reg_written), 16'(want.reg_written));
            report("reg_index", 16'(got.reg_index), 16'(want.reg_index));
            report("reg_value", got.reg_value, want.reg_value);
            report("mem_written", 16'(got.mem_written), 16'(want.mem_written));
            report("store_address", got.store_address, want.store_address);
            report("store_data", got.store_data, want.store_data);
            report("trap_taken", 16'(got.trap_taken), 16'(want.trap_taken));
            report("trap_vector", 16'(got.trap_vector), 16'(want.trap_vector));
            report("illegal", 16'(got.illegal), 16'(want.illegal));
         end
         recv_beats++;
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [15:0] cfg_values [0:3];
      for (int i = 0; i < 8; i++) gpr[i] = 16'd0;
      arch_pc = START_PC_RESET;
      arch_cc = CC_ZERO;
      start_pc_reg = START_PC_RESET;
      cfg_values[0] = 16'h0000;
      cfg_values[1] = 16'hFFFF;
      cfg_values[2] = 16'($urandom);
      cfg_values[3] = START_PC_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         // start_pc is never read by the executor, so these writes leave the PC alone
         csr_write(cfg_values[phase]);
         if (phase == 0) begin
            preload(16'h0000, 16'hFFFF);
            preload(16'hFFFF, 16'h0000);
            issue({OP_ADD, 3'd1, 3'd0, 1'b1, 5'b01111});
            issue({OP_ADD, 3'd2, 3'd1, 1'b1, 5'b10000});
            issue({OP_ADD, 3'd3, 3'd1, 1'b0, 2'b00, 3'd2});
            issue({OP_AND, 3'd4, 3'd2, 1'b1, 5'b10101});
            issue({OP_AND, 3'd5, 3'd3, 1'b0, 2'b00, 3'd1});
            issue({OP_NOT, 3'd6, 3'd0, 6'h3F});
            issue({OP_LEA, 3'd0, 9'h100});
            issue({OP_LD, 3'd1, 9'h0FF});
            issue({OP_LDI, 3'd2, 9'h1FF});
            issue({OP_LDR, 3'd3, 3'd6, 6'h20});
            issue({OP_ST, 3'd6, 9'h0AA});
            issue({OP_STI, 3'd2, 9'h155});
            issue({OP_STR, 3'd1, 3'd6, 6'h1F});
            issue({OP_BR, 3'b000, 9'h050});
            issue({OP_BR, 3'b111, 9'h1F0});
            issue({OP_JMP, 3'd0, 3'd6, 6'd0});
            issue({OP_JSR, 1'b1, 11'h400});
            issue({OP_JSR, 1'b0, 2'b00, 3'd7, 6'd0});
            issue({OP_TRAP, 4'd0, 8'h25});
            issue({OP_TRAP, 4'd0, 8'hFF});
            issue({OP_RTI, 12'hFFF});
            issue({OP_RES, 12'h000});
         end
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(99) < 20) preload(16'($urandom), 16'($urandom));
            else issue(16'($urandom));
         end
      end

      wait (pending_items.size() == 0 && predicted_results.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
